// ===== rtl/rgra_pkg.sv =====
// Shared constants, types and codes for the gated radar range averager.
package rgra_pkg;

    // Item and register field widths.
    localparam int COORD_W = 24;
    localparam int RANGE_W = 23;

    // Sizing of the frame accumulator and the mean window.
    localparam int MAX_POINTS = 256;
    localparam int WINDOW_LEN = 5;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = RANGE_W + $clog2(MAX_POINTS);
    localparam int TOT_W  = RANGE_W + $clog2(WINDOW_LEN + 1);
    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    // The serial divider works out the frame mean: sum over kept count.
    localparam int DIV_W     = SUM_W;
    localparam int DVS_W     = CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // The window average divides by a constant, so it is a multiply by a
    // rounded-up reciprocal and a shift. With the shift at TOT_W plus the
    // divisor's bit count, the rounding error never reaches the quotient.
    localparam int     AVG_SHIFT   = TOT_W + $clog2(WINDOW_LEN);
    localparam int     AVG_RECIP_W = TOT_W + 1;
    localparam int     AVG_PROD_W  = TOT_W + AVG_RECIP_W;
    localparam longint AVG_RECIP   =
        ((longint'(1) << AVG_SHIFT) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN);

    // Queue of closed frames between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // Stream and register port widths.
    localparam int IN_DATA_W  = 3 * COORD_W;
    localparam int OUT_DATA_W = ((RANGE_W + CNT_W + 7) / 8) * 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef enum logic {
        REG_LATERAL_LIMIT = 1'b0,
        REG_MIN_RANGE     = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } frame_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MEAN_START,
        B_MEAN_WAIT,
        B_WINDOW,
        B_AVG,
        B_EMIT
    } back_state_t;

endpackage

// ===== rtl/rgra_front.sv =====
// Front end: gates incoming points and accumulates kept ranges per frame.
module rgra_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic signed [rgra_pkg::COORD_W-1:0]  point_x,
    input  logic signed [rgra_pkg::COORD_W-1:0]  point_y,
    input  logic signed [rgra_pkg::COORD_W-1:0]  point_z,
    input  logic                                 frame_end,
    input  logic signed [rgra_pkg::COORD_W-1:0]  lateral_limit,
    input  logic        [rgra_pkg::RANGE_W-1:0]  min_range,
    input  logic                                 fifo_full,
    output logic                                 push,
    output rgra_pkg::frame_t                     push_data
);

    logic [rgra_pkg::SUM_W-1:0] sum_reg, sum_next, sum_acc;
    logic [rgra_pkg::CNT_W-1:0] count_reg, count_next, count_acc;
    logic                       keep;
    logic                       take;
    logic                       accept;

    // Stalling only on a full queue keeps the check simple; a frame end can
    // then always be pushed.
    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        // A range is kept only when it is positive and above the minimum.
        keep = (point_x < lateral_limit) && (point_z < lateral_limit) &&
               !point_y[rgra_pkg::COORD_W-1] &&
               (point_y[rgra_pkg::RANGE_W-1:0] > min_range);
        take = keep && (count_reg < rgra_pkg::CNT_W'(rgra_pkg::MAX_POINTS));
        sum_acc   = take ? sum_reg + rgra_pkg::SUM_W'(point_y[rgra_pkg::RANGE_W-1:0])
                         : sum_reg;
        count_acc = take ? count_reg + rgra_pkg::CNT_W'(1) : count_reg;

        push           = accept && frame_end && (count_acc != '0);
        push_data.sum   = sum_acc;
        push_data.count = count_acc;

        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept) begin
            sum_next   = frame_end ? '0 : sum_acc;
            count_next = frame_end ? '0 : count_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rgra_pkg::CNT_W'(rgra_pkg::MAX_POINTS))
        else $error("kept count exceeds the frame limit");

endmodule

// ===== rtl/rgra_fifo.sv =====
// Short queue of closed frames between the front and back ends.
module rgra_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rgra_pkg::frame_t push_data,
    input  logic             pop,
    output rgra_pkg::frame_t pop_data,
    output logic             full,
    output logic             empty
);

    rgra_pkg::frame_t                mem_reg [rgra_pkg::FIFO_DEPTH];
    logic [rgra_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rgra_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rgra_pkg::FIFO_PTR_W:0]   fill_reg, fill_next;

    assign full     = (fill_reg == (rgra_pkg::FIFO_PTR_W+1)'(rgra_pkg::FIFO_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("frame queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("frame queue read while empty");

endmodule

// ===== rtl/rgra_div.sv =====
// Restoring divider for the frame mean, one quotient bit per cycle.
module rgra_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  rgra_pkg::div_req_t req,
    output rgra_pkg::div_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [rgra_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [rgra_pkg::DVS_W-1:0]     rem_reg, rem_next;
    logic [rgra_pkg::DVS_W-1:0]     dvs_reg, dvs_next;
    logic [rgra_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [rgra_pkg::DVS_W:0]       trial;
    logic                           fits;

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_comb begin
        // The partial remainder stays below the divisor, so one extra bit
        // holds the shifted trial value.
        trial     = {rem_reg, quo_reg[rgra_pkg::DIV_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = rgra_pkg::DIV_CNT_W'(rgra_pkg::DIV_W);
            rem_next  = '0;
            dvs_next  = req.divisor;
            quo_next  = req.dividend;
        end else if (busy_reg) begin
            rem_next = fits ? rgra_pkg::DVS_W'(trial - {1'b0, dvs_reg})
                            : trial[rgra_pkg::DVS_W-1:0];
            quo_next = {quo_reg[rgra_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rgra_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== rtl/rgra_back.sv =====
// Back end: frame mean, window of recent means, window average and output register.
module rgra_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fifo_empty,
    input  rgra_pkg::frame_t             fifo_data,
    output logic                         pop,
    output rgra_pkg::div_req_t           div_req,
    input  rgra_pkg::div_rsp_t           div_rsp,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rgra_pkg::RANGE_W-1:0] range_average,
    output logic [rgra_pkg::CNT_W-1:0]   kept_points
);

    rgra_pkg::back_state_t state_reg, state_next;

    rgra_pkg::frame_t             frame_reg;
    logic [rgra_pkg::RANGE_W-1:0] mean_reg;
    logic [rgra_pkg::RANGE_W-1:0] avg_reg;
    logic [rgra_pkg::TOT_W-1:0]   total_reg, total_next;
    logic [rgra_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [rgra_pkg::RANGE_W-1:0] window_reg [rgra_pkg::WINDOW_LEN];
    logic                         out_valid_reg;
    logic [rgra_pkg::RANGE_W-1:0] out_avg_reg;
    logic [rgra_pkg::CNT_W-1:0]   out_cnt_reg;

    logic [rgra_pkg::AVG_PROD_W-1:0] avg_prod;
    logic [rgra_pkg::RANGE_W-1:0]    avg_calc;

    logic mean_load;
    logic window_we;
    logic avg_load;
    logic out_load;

    assign m_tvalid      = out_valid_reg;
    assign range_average = out_avg_reg;
    assign kept_points   = out_cnt_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rgra_pkg::B_IDLE: begin
                if (!fifo_empty) state_next = rgra_pkg::B_MEAN_START;
            end
            rgra_pkg::B_MEAN_START: state_next = rgra_pkg::B_MEAN_WAIT;
            rgra_pkg::B_MEAN_WAIT: begin
                if (div_rsp.done) state_next = rgra_pkg::B_WINDOW;
            end
            rgra_pkg::B_WINDOW:     state_next = rgra_pkg::B_AVG;
            rgra_pkg::B_AVG:        state_next = rgra_pkg::B_EMIT;
            rgra_pkg::B_EMIT: begin
                if (!out_valid_reg || m_tready) state_next = rgra_pkg::B_IDLE;
            end
            default: state_next = rgra_pkg::B_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        pop              = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = rgra_pkg::DIV_W'(frame_reg.sum);
        div_req.divisor  = rgra_pkg::DVS_W'(frame_reg.count);
        mean_load        = 1'b0;
        window_we        = 1'b0;
        avg_load         = 1'b0;
        out_load         = 1'b0;
        case (state_reg)
            rgra_pkg::B_IDLE:       pop = !fifo_empty;
            rgra_pkg::B_MEAN_START: div_req.start = 1'b1;
            rgra_pkg::B_MEAN_WAIT:  mean_load = div_rsp.done;
            rgra_pkg::B_WINDOW:     window_we = 1'b1;
            rgra_pkg::B_AVG:        avg_load = 1'b1;
            rgra_pkg::B_EMIT:       out_load = !out_valid_reg || m_tready;
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    // The window total is kept running: the slot being overwritten is
    // subtracted and the new mean added.
    always_comb begin
        slot_next  = (slot_reg == rgra_pkg::SLOT_W'(rgra_pkg::WINDOW_LEN - 1))
                   ? '0 : slot_reg + 1'b1;
        total_next = total_reg + rgra_pkg::TOT_W'(mean_reg)
                   - rgra_pkg::TOT_W'(window_reg[slot_next]);
    end

    // Window average: total times the reciprocal of the window length,
    // taking the bits above the shift. The quotient fits the range width.
    always_comb begin
        avg_prod = rgra_pkg::AVG_PROD_W'(total_reg)
                 * rgra_pkg::AVG_PROD_W'(rgra_pkg::AVG_RECIP);
        avg_calc = avg_prod[rgra_pkg::AVG_SHIFT +: rgra_pkg::RANGE_W];
    end

    always_ff @(posedge aclk) begin
        if (pop) frame_reg <= fifo_data;
        if (mean_load) mean_reg <= div_rsp.quotient[rgra_pkg::RANGE_W-1:0];
        if (avg_load) avg_reg <= avg_calc;
        if (out_load) begin
            out_avg_reg <= avg_reg;
            out_cnt_reg <= frame_reg.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rgra_pkg::B_IDLE;
            total_reg     <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < rgra_pkg::WINDOW_LEN; i++) begin
                window_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (window_we) begin
                total_reg             <= total_next;
                slot_reg              <= slot_next;
                window_reg[slot_next] <= mean_reg;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg < rgra_pkg::SLOT_W'(rgra_pkg::WINDOW_LEN))
        else $error("window slot out of range");

    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == rgra_pkg::B_MEAN_WAIT))
        else $error("divider finished while the sequencer was not waiting");

endmodule

// ===== rtl/radar_gated_range_average.sv =====
// Top level of the gated radar range averager: register port, front, queue, divider, back.
//
//  Channel   Direction  Transfer fields
//  s_*       in         tdata: point_x, point_y, point_z; tlast: frame_end
//  m_*       out        tdata: range_average, kept_points
//  APB       in/out     lateral_limit at 0x0, min_range at 0x4
//
// The front takes one point per cycle while the queue is not full, and gates and
// accumulates it in that cycle. A frame that closes with at least one kept point
// goes to the back end, where the serial divider works out the frame mean; the
// window average is a multiply by the reciprocal of the window length.
// Up to FIFO_DEPTH closed frames wait between the two; s_tready drops only while
// that queue is full. Reset is synchronous and clears accumulators, window and
// queue at once; there is no clearing pass. A stalled result holds in the output
// register while the back end starts on the next frame.
module radar_gated_range_average (
    input  logic                                aclk,
    input  logic                                aresetn,
    // point_x [23:0], point_y [47:24], point_z [71:48]
    input  logic [rgra_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    input  logic                                s_tlast,
    output logic                                s_tready,
    // range_average [22:0], kept_points [31:23]
    output logic [rgra_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rgra_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rgra_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rgra_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic signed [rgra_pkg::COORD_W-1:0] lateral_limit_reg;
    logic        [rgra_pkg::RANGE_W-1:0] min_range_reg;
    rgra_pkg::reg_index_t                reg_index;
    logic                                cfg_write;

    logic                         push;
    logic                         pop;
    logic                         fifo_full;
    logic                         fifo_empty;
    rgra_pkg::frame_t             push_data;
    rgra_pkg::frame_t             pop_data;
    rgra_pkg::div_req_t           div_req;
    rgra_pkg::div_rsp_t           div_rsp;
    logic [rgra_pkg::RANGE_W-1:0] range_average;
    logic [rgra_pkg::CNT_W-1:0]   kept_points;

    // Register file. Registers are word aligned, so bit 2 of the address
    // selects between them; the write lands in the access cycle.
    assign pready    = 1'b1;
    assign reg_index = rgra_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_index)
            rgra_pkg::REG_LATERAL_LIMIT:
                prdata = rgra_pkg::APB_DATA_W'(signed'(lateral_limit_reg));
            rgra_pkg::REG_MIN_RANGE:
                prdata = rgra_pkg::APB_DATA_W'(min_range_reg);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lateral_limit_reg <= rgra_pkg::COORD_W'(25600);
            min_range_reg     <= rgra_pkg::RANGE_W'(1536);
        end else if (cfg_write) begin
            case (reg_index)
                rgra_pkg::REG_LATERAL_LIMIT:
                    lateral_limit_reg <= pwdata[rgra_pkg::COORD_W-1:0];
                rgra_pkg::REG_MIN_RANGE:
                    min_range_reg <= pwdata[rgra_pkg::RANGE_W-1:0];
                default: begin
                    min_range_reg <= min_range_reg;
                end
            endcase
        end
    end

    // Gating and per-frame accumulation.
    rgra_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .point_x       (s_tdata[rgra_pkg::COORD_W-1:0]),
        .point_y       (s_tdata[2*rgra_pkg::COORD_W-1:rgra_pkg::COORD_W]),
        .point_z       (s_tdata[3*rgra_pkg::COORD_W-1:2*rgra_pkg::COORD_W]),
        .frame_end     (s_tlast),
        .lateral_limit (lateral_limit_reg),
        .min_range     (min_range_reg),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_data     (push_data)
    );

    // Closed frames wait here for the back end.
    rgra_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    // The divider works out each frame's mean range.
    rgra_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    rgra_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fifo_empty    (fifo_empty),
        .fifo_data     (pop_data),
        .pop           (pop),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .range_average (range_average),
        .kept_points   (kept_points)
    );

    assign m_tdata = rgra_pkg::OUT_DATA_W'({kept_points, range_average});

endmodule
